[src/hhxy_pkg.sv]
package hhxy_pkg;

   // Fixed field widths
   localparam int IndexWidth = 17;
   localparam int CoordWidth = 9;
   localparam int OrderWidth = 4;

   // Node index is the half-step index without its low bit
   localparam int NodeWidth = IndexWidth - 1;

   // Effective order; wide enough for any order code and for MAX_ORDER up to 31
   localparam int EffOrderWidth = 5;

   localparam logic [OrderWidth-1:0] OrderReset = OrderWidth'(3);

   typedef logic [IndexWidth-1:0] index_type;
   typedef logic [CoordWidth-1:0] coord_type;
   typedef logic [OrderWidth-1:0] order_type;
   typedef logic [NodeWidth-1:0]  node_type;

endpackage

[src/hhxy_if.sv]
interface hhxy_req_if import hhxy_pkg::*; ();
   logic      valid;
   logic      ready;
   index_type half_index;

   modport source (output valid, output half_index, input ready);
   modport sink   (input valid, input half_index, output ready);
endinterface

interface hhxy_rsp_if import hhxy_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type x_doubled;
   coord_type y_doubled;
   logic      clamped;

   modport source (output valid, output x_doubled, output y_doubled, output clamped,
                   input ready);
   modport sink   (input valid, input x_doubled, input y_doubled, input clamped,
                   output ready);
endinterface

[src/hilbert_half_index_to_xy.sv]
// Hilbert curve half-step index to doubled grid coordinates. Each item carries
// half_index = 2 * curve position; an even index yields one node, an odd index
// the midpoint of that node and the next. x_doubled / y_doubled are twice the
// grid coordinates (one fractional bit). Indices past the last node of the
// 2^n x 2^n grid return the last node with clamped set. The order n comes from
// the csr_ register (reset 3) and saturates at MAX_ORDER; write it only while
// no item is in flight. Throughput is one item per clock while rsp_chan.ready
// holds; an item passes through one input register, then the unrolled
// per-level walk for both neighbor nodes feeding the result register. Each
// stage advances independently, so an item is taken while a finished result
// waits on rsp_chan.ready, provided the input register is empty.
module hilbert_half_index_to_xy
   import hhxy_pkg::*;
#(
   parameter int MAX_ORDER = 8
) (
   input  logic             clock,
   input  logic             reset,
   hhxy_req_if.sink         req_chan,
   hhxy_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  order_type        csr_wr_data
);

   // Node coordinate width and zero-extended index width for the level walk
   localparam int NcW = MAX_ORDER;
   localparam int TW  = 2 * MAX_ORDER + NodeWidth;

   typedef logic [NcW-1:0] ncoord_type;

   // Curve index to node coordinates, one level per step, low level first
   function automatic void node_xy(input logic [EffOrderWidth-1:0] n,
                                   input node_type d,
                                   output ncoord_type px,
                                   output ncoord_type py);
      logic [TW-1:0] tt;
      ncoord_type    x, y, tmp, msk;
      logic          rx, ry;
      tt = TW'(d);
      x  = '0;
      y  = '0;
      for (int lvl = 0; lvl < MAX_ORDER; lvl++) begin
         if (EffOrderWidth'(lvl) < n) begin
            rx  = tt[2*lvl+1];
            ry  = tt[2*lvl] ^ rx;
            msk = (NcW'(1) << lvl) - NcW'(1);
            if (!ry) begin
               if (rx) begin
                  x = x ^ msk;   // s-1-x with x below s
                  y = y ^ msk;
               end
               tmp = x;
               x   = y;
               y   = tmp;
            end
            x[lvl] = rx;
            y[lvl] = ry;
         end
      end
      px = x;
      py = y;
   endfunction

   // Order register
   order_type order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= OrderReset;
      end else if (csr_wr_en) begin
         order_ff <= csr_wr_data;
      end
   end

   // Stage handshake: each stage loads when empty or when it drains
   logic      s1_valid_ff;
   index_type s1_index_ff;
   logic      s2_valid_ff;
   coord_type x_ff, y_ff;
   logic      clamp_ff;

   logic s2_load, s1_load;

   assign s2_load        = !s2_valid_ff || rsp_chan.ready;
   assign s1_load        = !s1_valid_ff || s2_load;
   assign req_chan.ready = s1_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_chan.valid) begin
         s1_index_ff <= req_chan.half_index;
      end
   end

   // Effective order, saturated
   logic [EffOrderWidth-1:0] n_eff;
   assign n_eff = (EffOrderWidth'(order_ff) > EffOrderWidth'(MAX_ORDER))
                ? EffOrderWidth'(MAX_ORDER) : EffOrderWidth'(order_ff);

   // Clamp: only reachable while the grid fits the node index
   logic [IndexWidth-1:0] last_in, node_ext;
   logic                  fits, clamp_in, mid;
   node_type              d0, d1;

   assign fits     = ({n_eff, 1'b0} <= (EffOrderWidth+1)'(NodeWidth));
   assign last_in  = (IndexWidth'(1) << {n_eff, 1'b0}) - IndexWidth'(1);
   assign node_ext = {1'b0, s1_index_ff[IndexWidth-1:1]};
   assign clamp_in = fits && ((node_ext > last_in) ||
                              (node_ext == last_in && s1_index_ff[0]));
   assign d0       = clamp_in ? last_in[NodeWidth-1:0] : s1_index_ff[IndexWidth-1:1];
   assign mid      = s1_index_ff[0] && !clamp_in;
   assign d1       = d0 + NodeWidth'(1);

   ncoord_type x0, y0, x1, y1;
   coord_type  x_in, y_in;

   always_comb begin
      node_xy(n_eff, d0, x0, y0);
      node_xy(n_eff, d1, x1, y1);
      if (mid) begin
         x_in = CoordWidth'({1'b0, x0} + {1'b0, x1});
         y_in = CoordWidth'({1'b0, y0} + {1'b0, y1});
      end else begin
         x_in = CoordWidth'({x0, 1'b0});
         y_in = CoordWidth'({y0, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load && s1_valid_ff) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         clamp_ff <= clamp_in;
      end
   end

   assign rsp_chan.valid     = s2_valid_ff;
   assign rsp_chan.x_doubled = x_ff;
   assign rsp_chan.y_doubled = y_ff;
   assign rsp_chan.clamped   = clamp_ff;

endmodule
